// ===== design/vas_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the voice allocator; no dependencies
package vas_pkg;

	localparam int MaxChannelsDef = 32;

	localparam logic [2:0] KIND_PLAY     = 3'd0;
	localparam logic [2:0] KIND_SET_PRIO = 3'd1;
	localparam logic [2:0] KIND_SET_PAUS = 3'd2;
	localparam logic [2:0] KIND_END      = 3'd3;
	localparam logic [2:0] KIND_UPDATE   = 3'd4;

	localparam logic [1:0] RES_GRANT   = 2'd0;
	localparam logic [1:0] RES_ENDED   = 2'd1;
	localparam logic [1:0] RES_SUMMARY = 2'd2;

	localparam logic [1:0] REG_MAX_CH  = 2'd0;
	localparam logic [1:0] REG_SW_CH   = 2'd1;
	localparam logic [1:0] REG_DEF_PRI = 2'd2;

	localparam logic [5:0] MAX_CH_RST  = 6'd32;
	localparam logic [5:0] SW_CH_RST   = 6'd32;
	localparam logic [8:0] DEF_PRI_RST = 9'd128;

	typedef struct packed {
		logic accept;
		logic pfind;
		logic pscan;
		logic steal;
		logic prep_emit;
		logic pgrant;
		logic urank;
		logic uend;
		logic usum;
	} cmd_t;

	typedef struct packed {
		logic is_play;
		logic is_update;
		logic hit;
		logic room;
		logic at_end;
		logic reported_pick;
		logic uend_emit;
		logic slot_free;
	} sts_t;

endpackage

// ===== design/voice_allocator_with_stealing.sv =====
// voice allocator top level: configuration registers, sequencer and channel table
// depends on vas_pkg, vas_ctrl, vas_dp
//
//  channel   handshake              payload
//  config    psel/penable/pready    paddr, pwdata, prdata
//  input     in_valid/in_ready      kind, channel_index, new_priority, pause_value
//  output    out_valid/out_ready    result_type .. last
//
// one item at a time; a table command completes when accepted, a play grants a
// reported or new channel, or, when it steals, scans every existing channel (one
// channel entry per cycle), then steals, reports if unreported and grants the
// pick; an update makes a ranking pass, then an end pass. reset clears all
// flags at once, no clearing pass. a full result register stalls the sequencer.
module voice_allocator_with_stealing #(
	parameter int MAX_CHANNELS = vas_pkg::MaxChannelsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [4:0]  channel_index,
	input  logic [8:0]  new_priority,
	input  logic        pause_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_type,
	output logic [4:0]  channel_index_out,
	output logic        was_stolen,
	output logic [5:0]  active_count,
	output logic [5:0]  audible_count,
	output logic [31:0] stolen_total,
	output logic        last
);
	import vas_pkg::*;

	logic [5:0] max_ch_q, sw_ch_q;
	logic [8:0] def_pri_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ch_q  <= MAX_CH_RST;
			sw_ch_q   <= SW_CH_RST;
			def_pri_q <= DEF_PRI_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MAX_CH:  max_ch_q  <= pwdata[5:0];
				REG_SW_CH:   sw_ch_q   <= pwdata[5:0];
				REG_DEF_PRI: def_pri_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_CH:  prdata = 32'(max_ch_q);
			REG_SW_CH:   prdata = 32'(sw_ch_q);
			REG_DEF_PRI: prdata = 32'(def_pri_q);
			default:     prdata = 32'd0;
		endcase
	end

	vas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vas_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.max_ch            (max_ch_q),
		.sw_ch             (sw_ch_q),
		.def_pri           (def_pri_q),
		.kind              (kind),
		.channel_index     (channel_index),
		.new_priority      (new_priority),
		.pause_value       (pause_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_type       (result_type),
		.channel_index_out (channel_index_out),
		.was_stolen        (was_stolen),
		.active_count      (active_count),
		.audible_count     (audible_count),
		.stolen_total      (stolen_total),
		.last              (last)
	);

endmodule

// ===== design/vas_ctrl.sv =====
// sequencer for play, update and table commands
// depends on vas_pkg
module vas_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vas_pkg::sts_t sts,
	output vas_pkg::cmd_t cmd
);
	import vas_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PFIND = 8'b0000_0010,
		S_PSCAN = 8'b0000_0100,
		S_PREP  = 8'b0000_1000,
		S_PGRNT = 8'b0001_0000,
		S_URANK = 8'b0010_0000,
		S_UEND  = 8'b0100_0000,
		S_USUM  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.is_play) state_d = S_PFIND;
					else if (sts.is_update) state_d = S_URANK;
				end
			end
			S_PFIND: begin
				cmd.pfind = 1'b1;
				state_d = (sts.hit || sts.room) ? S_PGRNT : S_PSCAN;
			end
			S_PSCAN: begin
				if (sts.at_end) begin
					cmd.steal = 1'b1;
					state_d = S_PREP;
				end else begin
					cmd.pscan = 1'b1;
				end
			end
			S_PREP: begin
				if (sts.reported_pick) begin
					state_d = S_PGRNT;
				end else if (sts.slot_free) begin
					cmd.prep_emit = 1'b1;
					state_d = S_PGRNT;
				end
			end
			S_PGRNT: begin
				if (sts.slot_free) begin
					cmd.pgrant = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_URANK: begin
				cmd.urank = 1'b1;
				if (sts.at_end) state_d = S_UEND;
			end
			S_UEND: begin
				if (sts.at_end) state_d = S_USUM;
				else if (!sts.uend_emit || sts.slot_free) cmd.uend = 1'b1;
			end
			S_USUM: begin
				if (sts.slot_free) begin
					cmd.usum = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== design/vas_dp.sv =====
// channel table, scan counter, steal search, ranking and result register
// depends on vas_pkg
module vas_dp #(
	parameter int MAX_CHANNELS = vas_pkg::MaxChannelsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vas_pkg::cmd_t cmd,
	output vas_pkg::sts_t sts,
	input  logic [5:0]    max_ch,
	input  logic [5:0]    sw_ch,
	input  logic [8:0]    def_pri,
	input  logic [2:0]    kind,
	input  logic [4:0]    channel_index,
	input  logic [8:0]    new_priority,
	input  logic          pause_value,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    result_type,
	output logic [4:0]    channel_index_out,
	output logic          was_stolen,
	output logic [5:0]    active_count,
	output logic [5:0]    audible_count,
	output logic [31:0]   stolen_total,
	output logic          last
);
	import vas_pkg::*;

	localparam int N  = MAX_CHANNELS;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int TW = $clog2(N + 1);

	logic [TW-1:0] total_q, i_q;
	logic [IW-1:0] pick_q, ii, cidx, hit_idx;
	logic [31:0]   play_stamp_q, steal_q, best_stamp_q;
	logic [8:0]    best_prio_q;
	logic          best_vld_q, stolen_q, pv_q;
	logic [8:0]    prio_q [N];
	logic [31:0]   stamp_q [N];
	logic [N-1:0]  active_q, reported_q, voice_q, paused_q, ended_q, virtual_q;
	logic [N-1:0]  cand, below;
	logic          hit, at_end, cmd_ok, act_n, take;
	logic [7:0]    lim, rank;
	logic [8:0]    pi;

	assign ii     = i_q[IW-1:0];
	assign cidx   = IW'(channel_index);
	assign at_end = (i_q >= total_q);
	assign cmd_ok = (8'(channel_index) < 8'(total_q)) && (8'(channel_index) < 8'(N));
	assign pi     = prio_q[ii];

	always_comb begin
		if (max_ch == 6'd0) lim = 8'd1;
		else if (8'(max_ch) > 8'(N)) lim = 8'(N);
		else lim = 8'(max_ch);
	end

	// lowest channel that ended and was reported
	assign cand = reported_q & ~voice_q;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int k = N - 1; k >= 0; k--) begin
			if (cand[k]) begin
				hit = 1'b1;
				hit_idx = IW'(k);
			end
		end
	end

	// rank of the scanned channel: active channels ahead of it
	always_comb begin
		for (int j = 0; j < N; j++) begin
			below[j] = active_q[j] && (IW'(j) != ii) &&
				((prio_q[j] < pi) || ((prio_q[j] == pi) && (IW'(j) < ii)));
		end
		rank = 8'($countones(below));
	end

	assign take = !best_vld_q || (pi > best_prio_q) ||
		((pi == best_prio_q) && (stamp_q[ii] < best_stamp_q));
	assign act_n = active_q[ii] && !(!paused_q[ii] && ended_q[ii]);

	assign sts.is_play       = (kind == KIND_PLAY);
	assign sts.is_update     = (kind == KIND_UPDATE);
	assign sts.hit           = hit;
	assign sts.room          = (8'(total_q) < lim);
	assign sts.at_end        = at_end;
	assign sts.reported_pick = reported_q[pick_q];
	assign sts.uend_emit     = voice_q[ii] && !act_n && !reported_q[ii];
	assign sts.slot_free     = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			i_q          <= '0;
			pick_q       <= '0;
			play_stamp_q <= '0;
			steal_q      <= '0;
			best_vld_q   <= 1'b0;
			stolen_q     <= 1'b0;
			pv_q         <= 1'b0;
			active_q     <= '0;
			reported_q   <= '0;
			voice_q      <= '0;
			paused_q     <= '0;
			ended_q      <= '0;
			virtual_q    <= '0;
		end else begin
			if (cmd.accept) begin
				i_q        <= '0;
				best_vld_q <= 1'b0;
				stolen_q   <= 1'b0;
				pv_q       <= pause_value;
				if (cmd_ok) begin
					if (kind == KIND_SET_PAUS) paused_q[cidx] <= pause_value;
					if (kind == KIND_END && voice_q[cidx]) ended_q[cidx] <= 1'b1;
				end
			end
			if (cmd.pfind) begin
				if (hit) begin
					pick_q <= hit_idx;
				end else if (8'(total_q) < lim) begin
					pick_q  <= total_q[IW-1:0];
					total_q <= total_q + 1'b1;
				end
			end
			if (cmd.pscan) begin
				if (take) begin
					pick_q       <= ii;
					best_prio_q  <= pi;
					best_stamp_q <= stamp_q[ii];
					best_vld_q   <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
			if (cmd.steal) begin
				active_q[pick_q] <= 1'b0;
				steal_q  <= steal_q + 32'd1;
				stolen_q <= 1'b1;
			end
			if (cmd.prep_emit) reported_q[pick_q] <= 1'b1;
			if (cmd.pgrant) begin
				play_stamp_q       <= play_stamp_q + 32'd1;
				active_q[pick_q]   <= 1'b1;
				voice_q[pick_q]    <= 1'b1;
				reported_q[pick_q] <= 1'b0;
				ended_q[pick_q]    <= 1'b0;
				virtual_q[pick_q]  <= 1'b0;
				paused_q[pick_q]   <= pv_q;
			end
			if (cmd.urank) begin
				if (at_end) begin
					i_q <= '0;
				end else begin
					if (active_q[ii]) virtual_q[ii] <= (rank >= 8'(sw_ch));
					i_q <= i_q + 1'b1;
				end
			end
			if (cmd.uend) begin
				i_q <= i_q + 1'b1;
				if (voice_q[ii]) begin
					active_q[ii] <= act_n;
					if (!act_n && !reported_q[ii]) begin
						reported_q[ii] <= 1'b1;
						voice_q[ii]    <= 1'b0;
					end
				end
			end
		end
	end

	// table payload, written only for started channels
	always_ff @(posedge clk) begin
		if (cmd.accept && cmd_ok && kind == KIND_SET_PRIO) prio_q[cidx] <= new_priority;
		if (cmd.pgrant) begin
			prio_q[pick_q]  <= def_pri;
			stamp_q[pick_q] <= play_stamp_q + 32'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.prep_emit || cmd.pgrant || cmd.usum || (cmd.uend && sts.uend_emit))
			out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep_emit || cmd.pgrant || cmd.usum || (cmd.uend && sts.uend_emit)) begin
			result_type       <= RES_ENDED;
			channel_index_out <= 5'd0;
			was_stolen        <= 1'b0;
			active_count      <= 6'd0;
			audible_count     <= 6'd0;
			stolen_total      <= steal_q;
			last              <= 1'b0;
			if (cmd.prep_emit) begin
				channel_index_out <= 5'(pick_q);
			end else if (cmd.pgrant) begin
				result_type       <= RES_GRANT;
				channel_index_out <= 5'(pick_q);
				was_stolen        <= stolen_q;
				last              <= 1'b1;
			end else if (cmd.usum) begin
				result_type   <= RES_SUMMARY;
				active_count  <= 6'($countones(active_q));
				audible_count <= 6'($countones(active_q & ~virtual_q));
				last          <= 1'b1;
			end else begin
				channel_index_out <= 5'(ii);
			end
		end
	end

endmodule
